// ===== hw/rtl/handle_hash_table_macros.svh =====
// Assertion macros for the handle hash table.
// Included by the top level; depends on nothing.
`ifndef HANDLE_HASH_TABLE_MACROS_SVH
`define HANDLE_HASH_TABLE_MACROS_SVH

// check cons in the same cycle as ante
`define HHT_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// check cons in the cycle after ante
`define HHT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hht_pkg.sv =====
// Shared types, codes and constants of the handle hash table.
// No dependencies.
package hht_pkg;

	localparam int CAPACITY   = 1024;
	localparam int SLOT_W     = $clog2(CAPACITY);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int TYPE_SHIFT = 56;
	localparam int TYPE_W     = 64 - TYPE_SHIFT;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int CFG_IDX_W  = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TYPE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TYPE = CFG_IDX_W'(1);

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EXISTS    = 3'd3,
		ST_NO_SPACE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_USED  = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_PUSH
	} f_state_t;

	typedef enum logic [1:0] {
		B_SWEEP,
		B_IDLE,
		B_READ,
		B_CHECK
	} b_state_t;

	typedef struct packed {
		op_t               op;
		logic              bad;
		logic [63:0]       handle;
		logic [63:0]       parent;
		logic [63:0]       native;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic [63:0] handle;
		logic [63:0] parent;
		logic [63:0] native;
	} rec_t;

	function automatic logic type_ok(input logic [TYPE_W-1:0] t, input logic [7:0] lo,
		input logic [7:0] hi);
		return (t >= lo) && (t <= hi);
	endfunction

	function automatic logic handle_ok(input logic [63:0] h, input logic [7:0] lo,
		input logic [7:0] hi);
		return type_ok(h[63:TYPE_SHIFT], lo, hi) && (h[TYPE_SHIFT-1:0] != '0);
	endfunction

endpackage

// ===== hw/rtl/hht_front.sv =====
// Front end: accepts operations, checks them and computes the start slot
// with an iterative 32x32 multiplier. Depends on hht_pkg.
module hht_front import hht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [63:0] handle_id,
	input  logic [7:0]  want_type,
	input  logic [63:0] parent_in,
	input  logic [63:0] native_in,
	input  logic [7:0]  min_type,
	input  logic [7:0]  max_type,
	input  logic        init_busy,
	output logic        q_valid,
	input  logic        q_ready,
	output cmd_t        q_data
);

	f_state_t    state_q, state_d;
	cmd_t        cmd_q, cmd_d;
	logic [2:0]  step_q, step_d;
	logic [63:0] a_q, a_d;
	logic [63:0] acc_q, acc_d;
	logic [63:0] prod_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_bw;
	logic        bad;
	op_t         op_in;

	assign op_in = op_t'(opcode);

	always_comb begin
		unique case (op_in)
			OP_INSERT: bad = !handle_ok(handle_id, min_type, max_type) || (native_in == '0)
				|| ((parent_in != '0) && !handle_ok(parent_in, min_type, max_type));
			OP_LOOKUP, OP_REMOVE: bad = !type_ok(want_type, min_type, max_type)
				|| (handle_id[63:TYPE_SHIFT] != want_type)
				|| (handle_id[TYPE_SHIFT-1:0] == '0);
			default: bad = 1'b0;
		endcase
	end

	assign mul_bw = step_q[2] ? MIX_C2 : MIX_C1;
	assign mul_a  = step_q[1] ? a_q[63:32] : a_q[31:0];
	assign mul_b  = (step_q[1:0] == 2'd1) ? mul_bw[63:32] : mul_bw[31:0];

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign in_ready = (state_q == F_IDLE) && !init_busy;
	assign q_valid  = (state_q == F_PUSH);

	always_comb begin
		q_data      = cmd_q;
		q_data.slot = acc_q[SLOT_W-1:0] ^ acc_q[31 +: SLOT_W];
	end

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		step_d  = step_q;
		a_d     = a_q;
		acc_d   = acc_q;
		unique case (state_q)
			F_IDLE: begin
				if (in_valid && in_ready) begin
					cmd_d.op     = op_in;
					cmd_d.bad    = bad;
					cmd_d.handle = handle_id;
					cmd_d.parent = parent_in;
					cmd_d.native = native_in;
					cmd_d.slot   = '0;
					a_d          = handle_id ^ (handle_id >> 30);
					step_d       = '0;
					state_d      = (bad || op_in == OP_CLEAR) ? F_PUSH : F_HASH;
				end
			end
			F_HASH: begin
				unique case (step_q[1:0])
					2'd0: acc_d = acc_q;
					2'd1: acc_d = prod_q;
					default: acc_d = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
				endcase
				if (step_q == 3'd3) begin
					a_d = acc_d ^ (acc_d >> 27);
				end
				step_d = step_q + 3'd1;
				if (step_q == 3'd7) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (q_ready) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		a_q   <= a_d;
		acc_q <= acc_d;
	end

endmodule

// ===== hw/rtl/hht_fifo.sv =====
// Short command queue between the front end and the probe engine.
// Depends on hht_pkg.
module hht_fifo import hht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_data
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push, pop;

	assign in_ready  = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

// ===== hw/rtl/hht_back.sv =====
// Probe engine: slot memories, linear probing, clearing sweep and the
// result register. Depends on hht_pkg.
module hht_back import hht_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  cmd_t           q_data,
	output logic           init_busy,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     status,
	output logic [63:0]    parent_out,
	output logic [63:0]    native_out
);

	mark_t             mark_mem [CAPACITY];
	rec_t              rec_mem  [CAPACITY];
	mark_t             mark_rd_q;
	rec_t              rec_rd_q;

	b_state_t          state_q, state_d;
	cmd_t              cmd_q, cmd_d;
	logic [SLOT_W-1:0] idx_q, idx_d, n_q, n_d, tomb_q, tomb_d;
	logic              tomb_v_q, tomb_v_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              reply_q, reply_d;
	logic              res_valid_q, res_valid_d;
	status_t           res_status_q, res_status_d;
	logic [63:0]       res_parent_q, res_parent_d, res_native_q, res_native_d;

	logic              mark_we, rec_we;
	logic [SLOT_W-1:0] wr_addr;
	mark_t             mark_wd;
	logic              last, match, tv_now;
	logic [SLOT_W-1:0] tslot;

	assign init_busy  = (state_q == B_SWEEP) && !reply_q;
	assign q_ready    = (state_q == B_IDLE) && !res_valid_q;
	assign out_valid  = res_valid_q;
	assign status     = res_status_q;
	assign parent_out = res_parent_q;
	assign native_out = res_native_q;

	assign last   = (n_q == SLOT_W'(CAPACITY - 1));
	assign match  = (mark_rd_q == MARK_USED) && (rec_rd_q.handle == cmd_q.handle);
	assign tv_now = tomb_v_q || (mark_rd_q == MARK_TOMB);
	assign tslot  = tomb_v_q ? tomb_q : idx_q;

	always_comb begin
		state_d      = state_q;
		cmd_d        = cmd_q;
		idx_d        = idx_q;
		n_d          = n_q;
		tomb_d       = tomb_q;
		tomb_v_d     = tomb_v_q;
		count_d      = count_q;
		reply_d      = reply_q;
		res_valid_d  = res_valid_q && !out_ready;
		res_status_d = res_status_q;
		res_parent_d = res_parent_q;
		res_native_d = res_native_q;
		mark_we      = 1'b0;
		rec_we       = 1'b0;
		wr_addr      = idx_q;
		mark_wd      = MARK_EMPTY;
		unique case (state_q)
			B_SWEEP: begin
				mark_we = 1'b1;
				idx_d   = idx_q + SLOT_W'(1);
				if (idx_q == SLOT_W'(CAPACITY - 1)) begin
					count_d = '0;
					state_d = B_IDLE;
					if (reply_q) begin
						res_valid_d  = 1'b1;
						res_status_d = ST_OK;
						res_parent_d = '0;
						res_native_d = '0;
					end
				end
			end
			B_IDLE: begin
				if (q_valid && q_ready) begin
					cmd_d        = q_data;
					res_parent_d = '0;
					res_native_d = '0;
					if (q_data.bad) begin
						res_valid_d  = 1'b1;
						res_status_d = ST_INVALID;
					end else if (q_data.op == OP_CLEAR) begin
						idx_d   = '0;
						reply_d = 1'b1;
						state_d = B_SWEEP;
					end else if (q_data.op == OP_INSERT
						&& count_q == CNT_W'(CAPACITY)) begin
						res_valid_d  = 1'b1;
						res_status_d = ST_NO_SPACE;
					end else begin
						idx_d    = q_data.slot;
						n_d      = '0;
						tomb_v_d = 1'b0;
						state_d  = B_READ;
					end
				end
			end
			B_READ: state_d = B_CHECK;
			B_CHECK: begin
				state_d      = B_IDLE;
				res_parent_d = '0;
				res_native_d = '0;
				if (cmd_q.op == OP_INSERT) begin
					if (match) begin
						res_valid_d  = 1'b1;
						res_status_d = ST_EXISTS;
					end else if (mark_rd_q == MARK_EMPTY || (last && tv_now)) begin
						wr_addr      = (mark_rd_q == MARK_EMPTY) ? tslot
							: (tomb_v_q ? tomb_q : idx_q);
						mark_we      = 1'b1;
						rec_we       = 1'b1;
						mark_wd      = MARK_USED;
						count_d      = count_q + CNT_W'(1);
						res_valid_d  = 1'b1;
						res_status_d = ST_OK;
					end else if (last) begin
						res_valid_d  = 1'b1;
						res_status_d = ST_NO_SPACE;
					end else begin
						if (mark_rd_q == MARK_TOMB && !tomb_v_q) begin
							tomb_d   = idx_q;
							tomb_v_d = 1'b1;
						end
						idx_d   = idx_q + SLOT_W'(1);
						n_d     = n_q + SLOT_W'(1);
						state_d = B_READ;
					end
				end else begin
					if (match) begin
						res_valid_d  = 1'b1;
						res_status_d = ST_OK;
						res_native_d = rec_rd_q.native;
						if (cmd_q.op == OP_LOOKUP) begin
							res_parent_d = rec_rd_q.parent;
						end else begin
							mark_we = 1'b1;
							mark_wd = MARK_TOMB;
							count_d = count_q - CNT_W'(1);
						end
					end else if (mark_rd_q == MARK_EMPTY || last) begin
						res_valid_d  = 1'b1;
						res_status_d = ST_NOT_FOUND;
					end else begin
						idx_d   = idx_q + SLOT_W'(1);
						n_d     = n_q + SLOT_W'(1);
						state_d = B_READ;
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[wr_addr] <= mark_wd;
		end
		if (rec_we) begin
			rec_mem[wr_addr] <= '{handle: cmd_q.handle, parent: cmd_q.parent,
				native: cmd_q.native};
		end
		mark_rd_q <= mark_mem[idx_q];
		rec_rd_q  <= rec_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_SWEEP;
			idx_q       <= '0;
			count_q     <= '0;
			reply_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			count_q     <= count_d;
			reply_q     <= reply_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		n_q          <= n_d;
		tomb_q       <= tomb_d;
		tomb_v_q     <= tomb_v_d;
		res_status_q <= res_status_d;
		res_parent_q <= res_parent_d;
		res_native_q <= res_native_d;
	end

endmodule

// ===== hw/rtl/handle_hash_table.sv =====
// Handle hash table top level: type range registers and the front end,
// queue and probe engine. Depends on hht_pkg and the macros header.
//
// Channels: operations on in_valid/in_ready (opcode, handle_id,
// want_type, parent_in, native_in), one result per operation on
// out_valid/out_ready (status, parent_out, native_out), and a write port
// cfg_valid/cfg_ready with cfg_index/cfg_data for the type range
// (index 0 lowest valid type, index 1 highest; other indexes are dropped).
// cfg_ready is always high; write the range only while the block is idle.
// From the input transfer to out_valid an operation is hashed, handed to
// the queue and probed slot by slot; each probe is one registered read of
// the slot memories. Operations that fail the checks skip the hashing and
// the probing. Clear sweeps every slot mark to empty before its result.
// The front end can hash the next operation with the iterative 32x32
// multiplier while the probe engine works on the previous operation.
// Reset: the slot marks are swept to empty, with in_ready low during the
// sweep. A stalled receiver holds the result; one more operation can be
// hashed and two queued behind it.
`include "handle_hash_table_macros.svh"

module handle_hash_table import hht_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [63:0]          handle_id,
	input  logic [7:0]           want_type,
	input  logic [63:0]          parent_in,
	input  logic [63:0]          native_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [63:0]          parent_out,
	output logic [63:0]          native_out,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0] min_type_q, max_type_q;
	logic       init_busy;
	logic       q_in_valid, q_in_ready, q_out_valid, q_out_ready;
	cmd_t       q_in_data, q_out_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_type_q <= 8'd1;
			max_type_q <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MIN_TYPE) begin
				min_type_q <= cfg_data;
			end
			if (cfg_index == CFG_MAX_TYPE) begin
				max_type_q <= cfg_data;
			end
		end
	end

	hht_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.handle_id     (handle_id),
		.want_type     (want_type),
		.parent_in     (parent_in),
		.native_in     (native_in),
		.min_type      (min_type_q),
		.max_type      (max_type_q),
		.init_busy     (init_busy),
		.q_valid       (q_in_valid),
		.q_ready       (q_in_ready),
		.q_data        (q_in_data)
	);

	hht_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_in_valid),
		.in_ready  (q_in_ready),
		.in_data   (q_in_data),
		.out_valid (q_out_valid),
		.out_ready (q_out_ready),
		.out_data  (q_out_data)
	);

	hht_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_out_valid),
		.q_ready    (q_out_ready),
		.q_data     (q_out_data),
		.init_busy  (init_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.parent_out (parent_out),
		.native_out (native_out)
	);

	`HHT_ASSERT_SAME(a_init_blocks_input, clk, arst_n, init_busy, !in_ready,
		"operation taken during the reset sweep")
	`HHT_ASSERT_SAME(a_fail_zero_payload, clk, arst_n,
		out_valid && (status != ST_OK),
		(parent_out == '0) && (native_out == '0), "failed result carries data")
	`HHT_ASSERT_SAME(a_status_range, clk, arst_n, out_valid,
		(status == ST_OK) || (status == ST_INVALID) || (status == ST_NOT_FOUND)
		|| (status == ST_EXISTS) || (status == ST_NO_SPACE), "status code out of range")
	`HHT_ASSERT_NEXT(a_init_no_result, clk, arst_n, init_busy && !out_valid,
		!out_valid, "result produced during the reset sweep")

endmodule
